// ----- src/shs_pkg.sv -----
// Shared types and constants of the sample history sparkline block.
package shs_pkg;

   localparam int CFG_W       = 16;  // width of the scale registers
   localparam int LEVEL_W     = 4;   // bits of one level
   localparam int NUM_FIELDS  = 4;   // level fields in one result beat
   localparam int FIELD_IDX_W = 2;   // index over the level fields
   localparam int STEP_W      = 2;   // divider step counter, LEVEL_W steps
   localparam int CSR_ADDR_W  = 1;
   localparam int RSP_W       = NUM_FIELDS * LEVEL_W;

   localparam logic [LEVEL_W-1:0]    LEVEL_TOP     = 4'd15;
   localparam logic [LEVEL_W-1:0]    LEVEL_ZERO    = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_MIN = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_MAX = 1'd1;
   localparam logic [CFG_W-1:0]      SCALE_MIN_RST = 16'd0;
   localparam logic [CFG_W-1:0]      SCALE_MAX_RST = 16'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_FLUSH
   } shs_state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/sample_history_sparkline_top.sv -----
// Top level of the sample history sparkline level quantizer.
//
// Usage: each req beat carries one unsigned sample (req_tdata). It is shifted
// into a chain of HISTORY_DEPTH cells, newest at cell 0, oldest at the tail.
// The history is split, oldest first, into GROUP_COUNT groups of
// HISTORY_DEPTH/GROUP_COUNT samples; each group is clamped to scale_max,
// averaged and quantized to a level 0..15 against scale_min..scale_max.
// One rsp beat per req beat carries four levels, newest group first.
// Flow: after a beat is accepted the chain rotates by whole turns, enough to
// see every group, so that each sample passes the accumulator at the tail.
// Finished group sums go to one shared divider, one level at a time,
// overlapping the rotation; the last group's divide and the output load
// finish the work on a beat.
// One beat is worked on at a time; the next req beat is taken as soon as the
// result sits in the rsp register, even if the receiver has not taken it.
// Stall: if the rsp register still holds a beat and rsp_tready is low, the
// finished levels wait in the block until it frees up; nothing is dropped.
// Reset (synchronous): history cleared to zero, scale_min=0, scale_max=100.
// Configuration writes via csr_* are expected only while the block is idle.
module sample_history_sparkline_top import shs_pkg::*; #(
   parameter int HISTORY_DEPTH = 16,
   parameter int GROUP_COUNT   = 4,
   parameter int SAMPLE_BITS   = 16,
   localparam int REQ_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // [SAMPLE_BITS-1:0] sample, zero pad above
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // level_newest in the low bits, level_second,
                                              // level_third, level_oldest on top (4b each)
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   // group geometry
   localparam int GS     = (HISTORY_DEPTH / GROUP_COUNT) > 0 ?
                           (HISTORY_DEPTH / GROUP_COUNT) : 1;
   localparam int NOUT   = GROUP_COUNT < NUM_FIELDS ? GROUP_COUNT : NUM_FIELDS;
   localparam int SKIP   = GROUP_COUNT - NOUT;   // oldest groups not reported
   // rotation length: whole turns of the chain, enough to see every group
   localparam int ROT    = HISTORY_DEPTH *
                           ((GROUP_COUNT * GS + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
   localparam int RCW    = $clog2(ROT + 1);
   localparam int JW     = GS > 1 ? $clog2(GS) : 1;
   localparam int GW     = $clog2(GROUP_COUNT + 1);
   localparam int KW     = $clog2(NOUT + 1);
   localparam int IW     = NOUT > 1 ? $clog2(NOUT) : 1;
   localparam int GSB    = $clog2(GS + 1);
   localparam int SUM_W  = CFG_W + GSB;
   localparam int CMP_W  = SAMPLE_BITS > CFG_W ? SAMPLE_BITS : CFG_W;

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] scale_min_ff, scale_min_in;
   logic [CFG_W-1:0] scale_max_ff, scale_max_in;

   always_comb begin
      scale_min_in = scale_min_ff;
      scale_max_in = scale_max_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_SCALE_MIN: scale_min_in = csr_wdata;
            REG_SCALE_MAX: scale_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_min_ff <= SCALE_MIN_RST;
         scale_max_ff <= SCALE_MAX_RST;
      end else begin
         scale_min_ff <= scale_min_in;
         scale_max_ff <= scale_max_in;
      end
   end

   // ---------------- sequencer ----------------
   shs_state_type state_ff, state_in;
   logic          accept;
   logic          run;
   logic          out_free;
   logic          load_out;
   logic          rot_active;
   logic          work_done;
   div_stat_type  div_stat;
   logic [KW-1:0] div_idx_ff, div_idx_in;

   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid | rsp_tready;
   assign work_done  = ~rot_active & (div_idx_ff == KW'(NOUT)) & ~div_stat.busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_BUSY;
         ST_BUSY:  if (work_done)  state_in = ST_FLUSH;
         ST_FLUSH: if (out_free)   state_in = ST_IDLE;
         default:                  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      run        = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_BUSY:  run        = 1'b1;
         ST_FLUSH: load_out   = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- history chain ----------------
   logic [SAMPLE_BITS-1:0] cell_q [HISTORY_DEPTH];
   logic [SAMPLE_BITS-1:0] head_d;
   logic [SAMPLE_BITS-1:0] tail;
   logic                   shift_en;

   assign tail     = cell_q[HISTORY_DEPTH-1];
   // new sample enters at the head; during rotation the tail wraps back
   assign head_d   = accept ? req_tdata[SAMPLE_BITS-1:0] : tail;
   assign shift_en = accept | (run & rot_active);

   genvar c;
   generate
      for (c = 0; c < HISTORY_DEPTH; c++) begin : g_cell
         if (c == 0) begin : g_head
            shs_cell #(.W(SAMPLE_BITS)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .d        (head_d),
               .q        (cell_q[c])
            );
         end else begin : g_body
            shs_cell #(.W(SAMPLE_BITS)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .d        (cell_q[c-1]),
               .q        (cell_q[c])
            );
         end
      end
   endgenerate

   // ---------------- group accumulator at the tail ----------------
   logic [RCW-1:0]   rot_cnt_ff, rot_cnt_in;
   logic [JW-1:0]    j_ff,       j_in;
   logic [GW-1:0]    g_ff,       g_in;
   logic [KW-1:0]    kept_ff,    kept_in;
   logic [SUM_W-1:0] acc_ff,     acc_in;
   logic [SUM_W-1:0] sum_mem_ff [NOUT];
   logic [CMP_W-1:0] tail_ext;
   logic [CMP_W-1:0] max_ext;
   logic [CFG_W-1:0] clamped;
   logic             in_range;
   logic             group_end;
   logic             keep_group;
   logic [SUM_W-1:0] acc_sum;

   assign rot_active = rot_cnt_ff != RCW'(ROT);
   assign tail_ext   = CMP_W'(tail);
   assign max_ext    = CMP_W'(scale_max_ff);
   assign clamped    = (tail_ext > max_ext) ? scale_max_ff : CFG_W'(tail_ext);
   assign in_range   = g_ff < GW'(GROUP_COUNT);
   assign acc_sum    = ((j_ff == '0) ? '0 : acc_ff) + SUM_W'(clamped);
   assign group_end  = run & rot_active & in_range & (j_ff == JW'(GS - 1));
   assign keep_group = g_ff >= GW'(SKIP);

   always_comb begin
      rot_cnt_in = rot_cnt_ff;
      j_in       = j_ff;
      g_in       = g_ff;
      kept_in    = kept_ff;
      acc_in     = acc_ff;
      if (accept) begin
         rot_cnt_in = '0;
         j_in       = '0;
         g_in       = '0;
         kept_in    = '0;
      end else if (run & rot_active) begin
         rot_cnt_in = rot_cnt_ff + 1'b1;
         if (in_range) begin
            acc_in = acc_sum;
            if (group_end) begin
               j_in = '0;
               g_in = g_ff + 1'b1;
               if (keep_group) begin
                  kept_in = kept_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_cnt_ff <= RCW'(ROT);
         j_ff       <= '0;
         g_ff       <= '0;
         kept_ff    <= '0;
      end else begin
         rot_cnt_ff <= rot_cnt_in;
         j_ff       <= j_in;
         g_ff       <= g_in;
         kept_ff    <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (group_end & keep_group) begin
         sum_mem_ff[kept_ff[IW-1:0]] <= acc_sum;
      end
   end

   // ---------------- scale terms, latched per beat ----------------
   logic [SUM_W-1:0] base_ff, base_in;
   logic [SUM_W-1:0] den_ff,  den_in;
   logic [SUM_W-1:0] top_ff,  top_in;
   logic             empty_ff, empty_in;

   always_comb begin
      base_in  = base_ff;
      den_in   = den_ff;
      top_in   = top_ff;
      empty_in = empty_ff;
      if (accept) begin
         base_in  = SUM_W'(scale_min_ff) * SUM_W'(GS);
         top_in   = SUM_W'(scale_max_ff) * SUM_W'(GS);
         den_in   = SUM_W'(scale_max_ff - scale_min_ff) * SUM_W'(GS);
         empty_in = scale_max_ff <= scale_min_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      den_ff   <= den_in;
      top_ff   <= top_in;
      empty_ff <= empty_in;
   end

   // ---------------- shared divider ----------------
   logic                     div_start;
   logic [LEVEL_W-1:0]       div_level;
   logic [FIELD_IDX_W-1:0]   field_sel;
   logic [LEVEL_W-1:0]       lvl_ff [NUM_FIELDS];

   assign div_start = run & ~div_stat.busy & (div_idx_ff < kept_ff);
   // kept groups arrive oldest first; the running one maps to field NOUT-div_idx
   assign field_sel = FIELD_IDX_W'(KW'(NOUT) - div_idx_ff);

   always_comb begin
      div_idx_in = div_idx_ff;
      if (accept) begin
         div_idx_in = '0;
      end else if (div_start) begin
         div_idx_in = div_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_idx_ff <= KW'(NOUT);
      end else begin
         div_idx_ff <= div_idx_in;
      end
   end

   shs_level_div #(.SUM_W(SUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sum_mem_ff[div_idx_ff[IW-1:0]]),
      .base  (base_ff),
      .den   (den_ff),
      .top   (top_ff),
      .empty (empty_ff),
      .stat  (div_stat),
      .level (div_level)
   );

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (accept) begin
            lvl_ff[i] <= LEVEL_ZERO;   // fields without a group stay zero
         end else if (div_stat.done && field_sel == FIELD_IDX_W'(i)) begin
            lvl_ff[i] <= div_level;
         end
      end
   end

   // ---------------- output register ----------------
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff,  rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            rsp_data_in[i*LEVEL_W +: LEVEL_W] = lvl_ff[i];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- src/shs_cell.sv -----
// One history cell: holds a sample and takes its neighbor's value on shift.
module shs_cell import shs_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] value_ff;
   logic [W-1:0] value_in;

   assign value_in = shift_en ? d : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

// ----- src/shs_level_div.sv -----
// Shared level divider: floor(16*(sum-base)/den), saturated, zero when empty, one bit a cycle.
module shs_level_div import shs_pkg::*; #(
   parameter int SUM_W = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   sum,
   input  logic [SUM_W-1:0]   base,
   input  logic [SUM_W-1:0]   den,
   input  logic [SUM_W-1:0]   top,   // base + den
   input  logic               empty,
   output div_stat_type       stat,
   output logic [LEVEL_W-1:0] level
);

   logic               busy_ff,  busy_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic [SUM_W-1:0]   rem_ff,   rem_in;
   logic [LEVEL_W-1:0] q_ff,     q_in;
   logic               sat_ff,   sat_in;
   logic               zero_ff,  zero_in;
   logic [SUM_W:0]     trial;
   logic [SUM_W:0]     trial_sub;
   logic               bit_set;
   logic               last_step;

   assign trial     = {rem_ff, 1'b0};
   assign trial_sub = trial - {1'b0, den};
   assign bit_set   = trial >= {1'b0, den};
   assign last_step = step_ff == STEP_W'(LEVEL_W - 1);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = (sum > base) ? (sum - base) : '0;
         q_in    = '0;
         sat_in  = sum >= top;  // only reached when the average sits at the maximum
         zero_in = empty;
      end else if (busy_ff) begin
         rem_in  = bit_set ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
         q_in    = {q_ff[LEVEL_W-2:0], bit_set};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      zero_ff <= zero_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff & last_step;
   assign level     = zero_ff ? LEVEL_ZERO :
                      sat_ff  ? LEVEL_TOP  : {q_ff[LEVEL_W-2:0], bit_set};

endmodule
